[hdl/pgt_pkg.sv]
// Package for the pool growth tracker: shared types and constants.
// No dependencies.
package pgt_pkg;

	localparam int unsigned WINDOW_RESET = 60;

	typedef struct packed {
		logic [31:0] now_secs;
		logic [31:0] used_leases;
		logic [31:0] pool_size;
	} sample_t;

	typedef struct packed {
		logic [31:0] used_clamped;
		logic [16:0] usage_q16;
		logic [31:0] growth;
		logic [47:0] growth_rate_q16;
		logic [31:0] exhaust_secs;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic write_ring;
		logic scan_start;
		logic scan_step;
		logic ref_prep;
		logic div_start;
		logic [1:0] div_sel;
		logic result_load;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_last;
		logic div_done;
	} dp_status_t;

	localparam logic [1:0] DIV_USAGE = 2'd0;
	localparam logic [1:0] DIV_RATE  = 2'd1;
	localparam logic [1:0] DIV_TTE   = 2'd2;

endpackage

[hdl/pgt_if.sv]
// Valid/ready channel interface used by the pool growth tracker.
// Depends on nothing; payload type is a parameter.
interface pgt_if #(parameter type PAYLOAD_T = logic [31:0]);
	logic valid;
	logic ready;
	PAYLOAD_T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/pgt_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module pgt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/pgt_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit dividend.
// No package dependency.
module pgt_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [32:0] remainder
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign trial = {1'b0, shifted} - {2'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

[hdl/pgt_datapath.sv]
// Datapath: sample registers, history ring, reference scan, divider, results.
// Depends on pgt_pkg, pgt_ram, pgt_divider.
module pgt_datapath #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pgt_pkg::sample_t    sample,
	input  logic [15:0]         window,
	input  pgt_pkg::dp_cmd_t    cmd,
	output pgt_pkg::dp_status_t status,
	output pgt_pkg::result_t    result
);
	import pgt_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic [31:0] now_q, used_q, total_q;
	logic [AW-1:0] wslot_q;
	logic [CW-1:0] filled_q;
	logic [CW-1:0] rd_cnt_q;
	logic          rd_vld_q;
	logic          found_q;
	logic [31:0]   ref_time_q, ref_used_q;
	logic [31:0]   elapsed_q, growth_q;
	logic [16:0]   usage_q;
	logic [47:0]   rate_q;
	logic          do_tte_q;
	result_t       result_q;
	logic [31:0]   rd_time, rd_used, rd_total;
	logic [31:0]   clamped;
	logic          hit;
	logic [63:0]   div_a;
	logic [31:0]   div_b;
	logic          div_done;
	logic [63:0]   div_quo;
	logic [32:0]   div_rem;
	logic [32:0]   tte_q33;
	logic [31:0]   tte;

	assign clamped = (sample.used_leases > sample.pool_size) ? sample.pool_size
		: sample.used_leases;

	pgt_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_time (
		.clk(clk), .we(cmd.write_ring), .waddr(wslot_q), .wdata(now_q),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(rd_time));
	pgt_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_used (
		.clk(clk), .we(cmd.write_ring), .waddr(wslot_q), .wdata(used_q),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(rd_used));
	pgt_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_total (
		.clk(clk), .we(cmd.write_ring), .waddr(wslot_q), .wdata(total_q),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(rd_total));

	// rd_vld_q marks that the RAM outputs hold the entry addressed last cycle
	assign hit = rd_vld_q && rd_total == total_q && rd_time <= now_q
		&& (now_q - rd_time) <= {16'd0, window}
		&& (!found_q || rd_time < ref_time_q);

	assign status.scan_last = !rd_vld_q && rd_cnt_q >= filled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q  <= '0;
			filled_q <= '0;
			rd_vld_q <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			if (cmd.write_ring) begin
				wslot_q <= (wslot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
				if (filled_q < CW'(HISTORY_DEPTH)) begin
					filled_q <= filled_q + 1'b1;
				end
			end
			if (cmd.scan_start) begin
				rd_cnt_q <= '0;
				rd_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (rd_cnt_q < filled_q) begin
					rd_vld_q <= 1'b1;
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end else begin
					rd_vld_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		div_a = '0;
		div_b = total_q;
		case (cmd.div_sel)
			DIV_USAGE: begin
				div_a = {16'd0, used_q, 16'd0};
				div_b = total_q;
			end
			DIV_RATE: begin
				div_a = {16'd0, growth_q, 16'd0};
				div_b = elapsed_q;
			end
			DIV_TTE: begin
				div_a = {32'd0, total_q - used_q} * {32'd0, elapsed_q};
				div_b = growth_q;
			end
			default: begin
				div_a = '0;
				div_b = total_q;
			end
		endcase
	end

	pgt_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_quo), .remainder(div_rem));
	assign status.div_done = div_done;

	assign tte_q33 = {1'b0, div_quo[31:0]} + 33'({div_rem, 1'b0} >= {2'b0, growth_q});
	assign tte = (div_quo[63:32] != 0 || tte_q33[32]) ? 32'hFFFF_FFFF : tte_q33[31:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q   <= sample.now_secs;
			used_q  <= clamped;
			total_q <= sample.pool_size;
		end
		if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q    <= 1'b1;
			ref_time_q <= rd_time;
			ref_used_q <= rd_used;
		end
		if (cmd.ref_prep) begin
			elapsed_q <= now_q - ref_time_q;
			if (found_q && now_q > ref_time_q && used_q > ref_used_q) begin
				growth_q <= used_q - ref_used_q;
			end else begin
				growth_q <= '0;
			end
		end
		if (div_done) begin
			case (cmd.div_sel)
				DIV_USAGE: usage_q <= div_quo[16:0];
				DIV_RATE:  rate_q <= div_quo[47:0];
				default:   ;
			endcase
		end
		if (cmd.ref_prep) begin
			rate_q <= '0;
		end
		do_tte_q <= growth_q != 0 && used_q < total_q;
		if (cmd.result_load) begin
			result_q.used_clamped    <= used_q;
			result_q.usage_q16       <= usage_q;
			result_q.growth          <= growth_q;
			result_q.growth_rate_q16 <= (growth_q != 0) ? rate_q : 48'd0;
			result_q.exhaust_secs    <= do_tte_q ? tte : 32'd0;
		end
	end

	assign result = result_q;
endmodule

[hdl/pgt_controller.sv]
// Controller FSM: sequences load, ring write, scan, three divisions, output.
// Depends on pgt_pkg.
module pgt_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                zero_total,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pgt_pkg::dp_status_t status,
	output pgt_pkg::dp_cmd_t    cmd
);
	import pgt_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WRITE  = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_PREP   = 4'd3;
	localparam logic [3:0] ST_DUSAGE = 4'd4;
	localparam logic [3:0] ST_DRATE  = 4'd5;
	localparam logic [3:0] ST_DTTE   = 4'd6;
	localparam logic [3:0] ST_WAIT   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic       ovalid_q;

	assign in_ready = state_q == ST_IDLE && !ovalid_q;
	assign out_valid = ovalid_q;

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.div_sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready && !zero_total) begin
					cmd.load = 1'b1;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_ring = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.ref_prep = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_USAGE;
				sel_d = DIV_USAGE;
				state_d = ST_DUSAGE;
			end
			ST_DUSAGE: begin
				if (status.div_done) begin
					sel_d = DIV_RATE;
					state_d = ST_DRATE;
				end
			end
			ST_DRATE: begin
				cmd.div_start = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) begin
					sel_d = DIV_TTE;
					state_d = ST_DTTE;
				end
			end
			ST_DTTE: begin
				cmd.div_start = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.div_done) begin
					cmd.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sel_q    <= DIV_USAGE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.result_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

[hdl/pool_growth_tracker_unit.sv]
// Top level of the pool growth tracker.
// Depends on pgt_pkg, pgt_if, pgt_controller, pgt_datapath.
//
// Channel   Dir  Payload
// sample_in in   now_secs, used_leases, pool_size
// cfg_in    in   history_window_secs (16 bits)
// result    out  used_clamped, usage_q16, growth, growth_rate_q16, exhaust_secs
//
// After a sample is taken, the result follows a ring write, a scan of the filled
// entries (at most HISTORY_DEPTH), then three serial divisions through one shared
// divider. Zero-total samples are accepted and dropped without a result. A new
// sample is taken no earlier than the edge after the result handoff.
// arst_n clears ring fill and returns the window to its reset value.
module pool_growth_tracker_unit #(
	parameter int HISTORY_DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	pgt_if.sink   sample_in,
	pgt_if.sink   cfg_in,
	pgt_if.source result
);
	import pgt_pkg::*;

	logic [15:0] window_q;
	dp_cmd_t     cmd;
	dp_status_t  status;
	sample_t     smp;
	result_t     res;

	assign smp = sample_in.data;
	assign result.data = res;
	assign cfg_in.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 16'(WINDOW_RESET);
		end else if (cfg_in.valid && cfg_in.ready) begin
			window_q <= cfg_in.data[15:0];
		end
	end

	pgt_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(sample_in.valid),
		.zero_total(smp.pool_size == 32'd0), .in_ready(sample_in.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.status(status), .cmd(cmd));

	pgt_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .sample(smp), .window(window_q),
		.cmd(cmd), .status(status), .result(res));
endmodule
